[hw/rtl/irpp_pkg.sv]
package irpp_pkg;

  localparam int MAX_PACKET_LEN     = 132;
  localparam int HDR_LEN            = 4;
  localparam int REPORT_MIN_PAYLOAD = 19;
  localparam int MIN_REPORT_LEN     = HDR_LEN + REPORT_MIN_PAYLOAD;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 15;
  localparam int WORD_W = 16;

  localparam logic [BYTE_W-1:0] TS_REPORT_ID = 8'hFB;
  localparam int SENSOR_ID_OFS  = 5;
  localparam int WORD_FIRST_OFS = 9;
  localparam int WORD_LAST_OFS  = 16;

  localparam int STAGE_WORDS = 4;
  localparam int SLOT_W      = $clog2(STAGE_WORDS);
  localparam int AXES        = 3;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORTS_CH = 2'd0,
    CFG_ACCEL_ID   = 2'd1,
    CFG_GYRO_ID    = 2'd2,
    CFG_ROT_ID     = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] RST_REPORTS_CH = 8'd3;
  localparam logic [CFG_DATA_W-1:0] RST_ACCEL_ID   = 8'd1;
  localparam logic [CFG_DATA_W-1:0] RST_GYRO_ID    = 8'd2;
  localparam logic [CFG_DATA_W-1:0] RST_ROT_ID     = 8'd5;

  localparam logic [1:0] ST_SAMPLE    = 2'd0;
  localparam logic [1:0] ST_NO_SAMPLE = 2'd1;
  localparam logic [1:0] ST_REJECT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_GYRO  = 2'd2,
    KIND_ROT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic              stage;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    logic              emit;
    logic              reject;
    kind_t             kind;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

[hw/rtl/irpp_ifs.sv]
interface irpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       packet_start;

  modport source (output valid, output rx_byte, output packet_start, input ready);
  modport sink (input valid, input rx_byte, input packet_start, output ready);
endinterface

interface irpp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic               attitude_ok;

  modport source (
    output valid, output status,
    output accel_x, output accel_y, output accel_z,
    output gyro_x, output gyro_y, output gyro_z,
    output quat_x, output quat_y, output quat_z, output quat_w,
    output attitude_ok,
    input ready
  );
  modport sink (
    input valid, input status,
    input accel_x, input accel_y, input accel_z,
    input gyro_x, input gyro_y, input gyro_z,
    input quat_x, input quat_y, input quat_z, input quat_w,
    input attitude_ok,
    output ready
  );
endinterface

[hw/rtl/irpp_front.sv]
module irpp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  irpp_in_if.sink                         in_ch,
  input  logic                            cfg_we,
  input  logic [irpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            q_full,
  output irpp_pkg::q_push_t               q_push
);
  import irpp_pkg::*;

  logic [CFG_DATA_W-1:0] reports_ch_r, accel_id_r, gyro_id_r, rot_id_r;

  logic              discarding_r, discarding_nxt;
  logic [IDX_W-1:0]  byte_index_r, byte_index_nxt;
  logic [BYTE_W-1:0] len_low_r, len_low_nxt;
  logic [IDX_W-1:0]  pkt_len_r, pkt_len_nxt;
  logic [BYTE_W-1:0] chan_r, chan_nxt;
  logic              ts_seen_r, ts_seen_nxt;
  kind_t             kind_r, kind_nxt;
  logic [BYTE_W-1:0] low_hold_r, low_hold_nxt;

  logic              accept;
  logic [LEN_W-1:0]  len_w;
  logic              len_bad;
  logic [IDX_W-1:0]  p_ofs;
  logic [IDX_W-1:0]  p_word;
  logic              last_byte;
  logic              commit_ok;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & ~q_full;

  assign len_w     = {in_ch.rx_byte[6:0], len_low_r};
  assign len_bad   = (len_w <= LEN_W'(HDR_LEN)) || (len_w > LEN_W'(MAX_PACKET_LEN));
  assign p_ofs     = byte_index_r - IDX_W'(HDR_LEN);
  assign p_word    = p_ofs - IDX_W'(WORD_FIRST_OFS + 1);
  assign last_byte = ({1'b0, byte_index_r} + 9'd1) >= {1'b0, pkt_len_r};
  assign commit_ok = (chan_r == reports_ch_r) && (pkt_len_r >= IDX_W'(MIN_REPORT_LEN))
                     && ts_seen_r;

  always_comb begin
    discarding_nxt = discarding_r;
    byte_index_nxt = byte_index_r;
    len_low_nxt    = len_low_r;
    pkt_len_nxt    = pkt_len_r;
    chan_nxt       = chan_r;
    ts_seen_nxt    = ts_seen_r;
    kind_nxt       = kind_r;
    low_hold_nxt   = low_hold_r;
    q_push         = '0;
    q_push.entry.kind = KIND_NONE;
    if (accept) begin
      if (in_ch.packet_start) begin
        discarding_nxt = 1'b0;
        len_low_nxt    = in_ch.rx_byte;
        ts_seen_nxt    = 1'b0;
        kind_nxt       = KIND_NONE;
        byte_index_nxt = IDX_W'(1);
      end else if (!discarding_r) begin
        byte_index_nxt = byte_index_r + IDX_W'(1);
        if (byte_index_r == IDX_W'(1)) begin
          if (len_bad) begin
            discarding_nxt      = 1'b1;
            q_push.valid        = 1'b1;
            q_push.entry.emit   = 1'b1;
            q_push.entry.reject = 1'b1;
          end else begin
            pkt_len_nxt = len_w[IDX_W-1:0];
          end
        end else if (byte_index_r == IDX_W'(2)) begin
          chan_nxt = in_ch.rx_byte;
        end else if (byte_index_r >= IDX_W'(HDR_LEN)) begin
          if (p_ofs == '0) begin
            ts_seen_nxt = (in_ch.rx_byte == TS_REPORT_ID);
          end else if (p_ofs == IDX_W'(SENSOR_ID_OFS)) begin
            if (in_ch.rx_byte == accel_id_r) begin
              kind_nxt = KIND_ACCEL;
            end else if (in_ch.rx_byte == gyro_id_r) begin
              kind_nxt = KIND_GYRO;
            end else if (in_ch.rx_byte == rot_id_r) begin
              kind_nxt = KIND_ROT;
            end else begin
              kind_nxt = KIND_NONE;
            end
          end else if (p_ofs >= IDX_W'(WORD_FIRST_OFS) && p_ofs <= IDX_W'(WORD_LAST_OFS)) begin
            if (p_ofs[0]) begin
              low_hold_nxt = in_ch.rx_byte;
            end else begin
              q_push.valid       = 1'b1;
              q_push.entry.stage = 1'b1;
              q_push.entry.slot  = p_word[SLOT_W:1];
              q_push.entry.word  = {in_ch.rx_byte, low_hold_r};
            end
          end
          if (last_byte) begin
            discarding_nxt    = 1'b1;
            q_push.valid      = 1'b1;
            q_push.entry.emit = 1'b1;
            q_push.entry.kind = commit_ok ? kind_r : KIND_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discarding_r <= 1'b1;
      byte_index_r <= '0;
      len_low_r    <= '0;
      pkt_len_r    <= '0;
      chan_r       <= '0;
      ts_seen_r    <= 1'b0;
      kind_r       <= KIND_NONE;
      low_hold_r   <= '0;
    end else begin
      discarding_r <= discarding_nxt;
      byte_index_r <= byte_index_nxt;
      len_low_r    <= len_low_nxt;
      pkt_len_r    <= pkt_len_nxt;
      chan_r       <= chan_nxt;
      ts_seen_r    <= ts_seen_nxt;
      kind_r       <= kind_nxt;
      low_hold_r   <= low_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reports_ch_r <= RST_REPORTS_CH;
      accel_id_r   <= RST_ACCEL_ID;
      gyro_id_r    <= RST_GYRO_ID;
      rot_id_r     <= RST_ROT_ID;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_REPORTS_CH: reports_ch_r <= cfg_wdata;
        CFG_ACCEL_ID:   accel_id_r   <= cfg_wdata;
        CFG_GYRO_ID:    gyro_id_r    <= cfg_wdata;
        CFG_ROT_ID:     rot_id_r     <= cfg_wdata;
        default:        reports_ch_r <= reports_ch_r;
      endcase
    end
  end

endmodule

[hw/rtl/irpp_queue.sv]
module irpp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  irpp_pkg::q_push_t q_push,
  output logic              q_full,
  output irpp_pkg::q_head_t q_head,
  input  logic              q_pop
);
  import irpp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];
  assign do_push      = q_push.valid & ~q_full;
  assign do_pop       = q_pop & q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

[hw/rtl/irpp_back.sv]
module irpp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  irpp_pkg::q_head_t q_head,
  output logic              q_pop,
  irpp_out_if.source        out_ch
);
  import irpp_pkg::*;

  logic [STAGE_WORDS-1:0][WORD_W-1:0] staged_r, staged_nxt;
  logic [AXES-1:0][WORD_W-1:0]        accel_r, accel_nxt;
  logic [AXES-1:0][WORD_W-1:0]        gyro_r, gyro_nxt;
  logic [STAGE_WORDS-1:0][WORD_W-1:0] quat_r, quat_nxt;
  logic                               sample_valid_r, sample_valid_nxt;
  logic                               attitude_r, attitude_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic [1:0]                         o_status_r;
  logic [AXES-1:0][WORD_W-1:0]        o_accel_r, o_gyro_r;
  logic [STAGE_WORDS-1:0][WORD_W-1:0] o_quat_r;
  logic                               o_att_r;
  logic                               load_out;

  assign q_pop = q_head.valid & (~q_head.entry.emit | ~out_valid_r | out_ch.ready);
  assign load_out = q_pop & q_head.entry.emit;

  always_comb begin
    staged_nxt       = staged_r;
    accel_nxt        = accel_r;
    gyro_nxt         = gyro_r;
    quat_nxt         = quat_r;
    sample_valid_nxt = sample_valid_r;
    attitude_nxt     = attitude_r;
    out_valid_nxt    = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      if (q_head.entry.stage) begin
        staged_nxt[q_head.entry.slot] = q_head.entry.word;
      end
      if (q_head.entry.emit) begin
        out_valid_nxt = 1'b1;
        unique case (q_head.entry.kind)
          KIND_ACCEL: begin
            accel_nxt        = staged_nxt[AXES-1:0];
            sample_valid_nxt = 1'b1;
          end
          KIND_GYRO: begin
            gyro_nxt         = staged_nxt[AXES-1:0];
            sample_valid_nxt = 1'b1;
          end
          KIND_ROT: begin
            quat_nxt         = staged_nxt;
            attitude_nxt     = 1'b1;
            sample_valid_nxt = 1'b1;
          end
          default: begin
            accel_nxt = accel_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      staged_r       <= '0;
      accel_r        <= '0;
      gyro_r         <= '0;
      quat_r         <= '0;
      sample_valid_r <= 1'b0;
      attitude_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      staged_r       <= staged_nxt;
      accel_r        <= accel_nxt;
      gyro_r         <= gyro_nxt;
      quat_r         <= quat_nxt;
      sample_valid_r <= sample_valid_nxt;
      attitude_r     <= attitude_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r <= q_head.entry.reject ? ST_REJECT :
                    (sample_valid_nxt ? ST_SAMPLE : ST_NO_SAMPLE);
      o_accel_r  <= accel_nxt;
      o_gyro_r   <= gyro_nxt;
      o_quat_r   <= quat_nxt;
      o_att_r    <= attitude_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.accel_x     = $signed(o_accel_r[0]);
  assign out_ch.accel_y     = $signed(o_accel_r[1]);
  assign out_ch.accel_z     = $signed(o_accel_r[2]);
  assign out_ch.gyro_x      = $signed(o_gyro_r[0]);
  assign out_ch.gyro_y      = $signed(o_gyro_r[1]);
  assign out_ch.gyro_z      = $signed(o_gyro_r[2]);
  assign out_ch.quat_x      = $signed(o_quat_r[0]);
  assign out_ch.quat_y      = $signed(o_quat_r[1]);
  assign out_ch.quat_z      = $signed(o_quat_r[2]);
  assign out_ch.quat_w      = $signed(o_quat_r[3]);
  assign out_ch.attitude_ok = o_att_r;

endmodule

[hw/rtl/imu_report_packet_parser.sv]
// Sensor report packet parser.
// in_ch carries one received packet byte per word, with packet_start set on
// the first header byte. The header gives a 15-bit little-endian length and
// a channel byte. out_ch carries one result per packet: status 2 at the
// second header byte when the length is rejected, otherwise status 0 or 1 at
// the packet's last byte, always with the latched accel, gyro and quaternion
// words and attitude_ok. cfg_we/cfg_index/cfg_wdata write the reports
// channel and the three sensor ids; write them only while idle.
// Throughput: one byte per cycle while the queue is not full. A result
// reaches out_ch through the queue write, then the queue head moving into
// the output register, which waits while out_ch holds an unaccepted result.
// A four-entry queue sits between the byte front end and the store/output
// back end; in_ch.ready drops only when that queue is full, which happens
// only while out_ch is stalled with results pending behind it.
// Reset: config registers return to defaults, stores clear to zero and the
// parser waits for a start mark. No clearing pass is needed.
module imu_report_packet_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  irpp_in_if.sink                         in_ch,
  irpp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [irpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import irpp_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  irpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  irpp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  irpp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> (in_ch.valid && in_ch.ready))
    else $error("queue push without an accepted byte");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue pop while empty");

  a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.entry.emit && q_head.entry.reject)
      |=> (out_ch.valid && out_ch.status == ST_REJECT))
    else $error("rejected packet did not produce a reject result");

endmodule
